FILE: rtl/frc_pkg.sv
// ----------------------------------------------------------------------------
// frc_pkg: shared definitions for the framed record checker
// Holds the record layout, FNV-1a 64 constants, status codes, register
// indexes and the result record type used between the checker modules.
// ----------------------------------------------------------------------------
package frc_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned HASH_W    = 64;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned COUNT_W   = 33;
	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned CFG_DAT_W = 64;

	localparam logic [COUNT_W-1:0] MAGIC_END    = COUNT_W'(8);
	localparam logic [COUNT_W-1:0] VERSION_END  = COUNT_W'(8 + 4);
	localparam logic [COUNT_W-1:0] LENGTH_END   = COUNT_W'(8 + 4 + 4);
	localparam logic [COUNT_W-1:0] HEADER_BYTES = COUNT_W'(8 + 4 + 4 + 8);
	localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};

	localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
	localparam logic [HASH_W-1:0] MAGIC_RESET = 64'h5653_3939_4F4E_4F4D;
	localparam logic [WORD_W-1:0] VERSION_RESET = 32'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MAGIC   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_VERSION = CFG_IDX_W'(1);

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_MAGIC    = 3'd2,
		ST_VERSION  = 3'd3,
		ST_LENGTH   = 3'd4,
		ST_CHECKSUM = 3'd5
	} status_t;

	typedef struct packed {
		status_t             status;
		logic                record_ok;
		logic [HASH_W-1:0]   payload_hash;
	} result_t;

	// One FNV-1a 64 round. The prime is 2^40 + 0x1B3, so the multiply is
	// a sum of shifted copies (bits 40, 8, 7, 5, 4, 1 and 0).
	function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
			input logic [BYTE_W-1:0] b);
		logic [HASH_W-1:0] x;
		x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4)
			+ (x << 1) + x;
	endfunction

endpackage

FILE: rtl/frc_if.sv
// ----------------------------------------------------------------------------
// frc_if: handshake channels of the framed record checker
// Byte input channel, result channel and register write channel, each with
// valid, ready and its payload.
// ----------------------------------------------------------------------------
interface frc_byte_if;
	logic                        valid;
	logic                        ready;
	logic [frc_pkg::BYTE_W-1:0]  data_byte;
	logic                        last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface frc_result_if;
	logic                        valid;
	logic                        ready;
	logic [2:0]                  status;
	logic                        record_ok;
	logic [frc_pkg::HASH_W-1:0]  payload_hash;

	modport source (output valid, output status, output record_ok,
		output payload_hash, input ready);
	modport sink (input valid, input status, input record_ok,
		input payload_hash, output ready);
endinterface

interface frc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [frc_pkg::CFG_IDX_W-1:0]  index;
	logic [frc_pkg::CFG_DAT_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/frc_cfg_regs.sv
// ----------------------------------------------------------------------------
// frc_cfg_regs: configuration registers
// Holds the expected magic word and format version; writes to unknown
// indexes are dropped.
// ----------------------------------------------------------------------------
module frc_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	frc_cfg_if.sink                     cfg,
	output logic [frc_pkg::HASH_W-1:0]  magic_word,
	output logic [frc_pkg::WORD_W-1:0]  expected_version
);

	logic [frc_pkg::HASH_W-1:0] magic_q;
	logic [frc_pkg::WORD_W-1:0] version_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= frc_pkg::MAGIC_RESET;
			version_q <= frc_pkg::VERSION_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				frc_pkg::REG_MAGIC:   magic_q   <= cfg.data;
				frc_pkg::REG_VERSION: version_q <= cfg.data[frc_pkg::WORD_W-1:0];
				default: ;
			endcase
		end
	end

	assign magic_word       = magic_q;
	assign expected_version = version_q;

endmodule

FILE: rtl/frc_record.sv
// ----------------------------------------------------------------------------
// frc_record: input register and per-record state
// Registers each byte, checks the magic, captures the header fields, runs
// the payload hash and forms the result when the last byte is processed.
// ----------------------------------------------------------------------------
module frc_record (
	input  logic                        clk,
	input  logic                        arst_n,
	frc_byte_if.sink                    byte_ch,
	input  logic [frc_pkg::HASH_W-1:0]  magic_word,
	input  logic [frc_pkg::WORD_W-1:0]  expected_version,
	input  logic                        out_free,
	output logic                        res_valid,
	output frc_pkg::result_t            res
);

	logic                               valid_s1;
	logic [frc_pkg::BYTE_W-1:0]         byte_s1;
	logic                               last_s1;

	logic [frc_pkg::COUNT_W-1:0]        count_q;
	logic                               magic_bad_q;
	logic [frc_pkg::WORD_W-1:0]         version_q;
	logic [frc_pkg::WORD_W-1:0]         length_q;
	logic [frc_pkg::HASH_W-1:0]         checksum_q;
	logic [frc_pkg::HASH_W-1:0]         hash_q;

	logic [frc_pkg::COUNT_W-1:0]        count_nx;
	logic                               magic_bad_nx;
	logic [frc_pkg::WORD_W-1:0]         version_nx;
	logic [frc_pkg::WORD_W-1:0]         length_nx;
	logic [frc_pkg::HASH_W-1:0]         checksum_nx;
	logic [frc_pkg::HASH_W-1:0]         hash_nx;
	logic [frc_pkg::BYTE_W-1:0]         want;
	logic                               advance;
	frc_pkg::status_t                   st;

	// A byte leaves the input register unless it closes a record whose
	// result cannot be stored yet.
	assign advance       = valid_s1 && (!last_s1 || out_free);
	assign byte_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.ready && byte_ch.valid) begin
			byte_s1 <= byte_ch.data_byte;
			last_s1 <= byte_ch.last_byte;
		end
	end

	always_comb begin
		count_nx     = count_q;
		magic_bad_nx = magic_bad_q;
		version_nx   = version_q;
		length_nx    = length_q;
		checksum_nx  = checksum_q;
		hash_nx      = hash_q;
		want         = magic_word[{count_q[2:0], 3'b000} +: frc_pkg::BYTE_W];
		if (count_q < frc_pkg::MAGIC_END) begin
			if (want != byte_s1) begin
				magic_bad_nx = 1'b1;
			end
		end else if (count_q < frc_pkg::VERSION_END) begin
			version_nx[{count_q[1:0], 3'b000} +: frc_pkg::BYTE_W] =
				version_q[{count_q[1:0], 3'b000} +: frc_pkg::BYTE_W] | byte_s1;
		end else if (count_q < frc_pkg::LENGTH_END) begin
			length_nx[{count_q[1:0], 3'b000} +: frc_pkg::BYTE_W] =
				length_q[{count_q[1:0], 3'b000} +: frc_pkg::BYTE_W] | byte_s1;
		end else if (count_q < frc_pkg::HEADER_BYTES) begin
			checksum_nx[{count_q[2:0], 3'b000} +: frc_pkg::BYTE_W] =
				checksum_q[{count_q[2:0], 3'b000} +: frc_pkg::BYTE_W] | byte_s1;
		end else begin
			hash_nx = frc_pkg::fnv_step(hash_q, byte_s1);
		end
		if (count_q != frc_pkg::COUNT_MAX) begin
			count_nx = count_q + frc_pkg::COUNT_W'(1);
		end
	end

	// Status in header order; the first failing check wins.
	always_comb begin
		if (count_nx < frc_pkg::HEADER_BYTES) begin
			st = frc_pkg::ST_SHORT;
		end else if (magic_bad_nx) begin
			st = frc_pkg::ST_MAGIC;
		end else if (version_nx != expected_version) begin
			st = frc_pkg::ST_VERSION;
		end else if (count_nx == frc_pkg::COUNT_MAX
				|| (count_nx - frc_pkg::HEADER_BYTES) != {1'b0, length_nx}) begin
			st = frc_pkg::ST_LENGTH;
		end else if (hash_nx != checksum_nx) begin
			st = frc_pkg::ST_CHECKSUM;
		end else begin
			st = frc_pkg::ST_OK;
		end
	end

	assign res_valid        = valid_s1 && last_s1;
	assign res.status       = st;
	assign res.record_ok    = (st == frc_pkg::ST_OK);
	assign res.payload_hash = hash_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			magic_bad_q <= 1'b0;
			version_q   <= '0;
			length_q    <= '0;
			checksum_q  <= '0;
			hash_q      <= frc_pkg::FNV_BASIS;
		end else if (advance) begin
			if (last_s1) begin
				count_q     <= '0;
				magic_bad_q <= 1'b0;
				version_q   <= '0;
				length_q    <= '0;
				checksum_q  <= '0;
				hash_q      <= frc_pkg::FNV_BASIS;
			end else begin
				count_q     <= count_nx;
				magic_bad_q <= magic_bad_nx;
				version_q   <= version_nx;
				length_q    <= length_nx;
				checksum_q  <= checksum_nx;
				hash_q      <= hash_nx;
			end
		end
	end

endmodule

FILE: rtl/frc_out_reg.sv
// ----------------------------------------------------------------------------
// frc_out_reg: result register
// Holds one finished result until the consumer takes it.
// ----------------------------------------------------------------------------
module frc_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	input  frc_pkg::result_t  res,
	output logic              out_free,
	frc_result_if.source      result_ch
);

	logic             valid_q;
	frc_pkg::result_t res_q;

	assign out_free = !valid_q || result_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			res_q <= res;
		end
	end

	assign result_ch.valid        = valid_q;
	assign result_ch.status       = res_q.status;
	assign result_ch.record_ok    = res_q.record_ok;
	assign result_ch.payload_hash = res_q.payload_hash;

endmodule

FILE: rtl/framed_record_checker_fnv1a64_top.sv
// ----------------------------------------------------------------------------
// framed_record_checker_fnv1a64_top: framed record checker with FNV-1a 64
// Checks a byte stream of records (24-byte header, then payload) and gives
// one status and payload hash per record.
// ----------------------------------------------------------------------------
//
//  Channel    Dir  Payload                                  Moves
//  byte_ch    in   data_byte[7:0], last_byte                one record byte
//  result_ch  out  status[2:0], record_ok, payload_hash     one record verdict
//  cfg_ch     in   index[3:0], data[63:0]                   one register write
//
// Each byte is captured in the input register and from there passes through
// the header capture, FNV round and status logic into the per-record
// state, or into the result register on the last byte; the input register
// takes a new byte as the held one moves on. The constant-prime multiply
// (a handful of shifted 64-bit adds) sets the clock. A result passes from
// the input register into the result register, where the consumer takes it.
// Reset loads the register defaults and starts a new record. When the
// result register is full and not being drained, a last byte waits in the
// input register and byte_ch.ready drops; other bytes keep flowing.
//
module framed_record_checker_fnv1a64_top (
	input  logic          clk,
	input  logic          arst_n,
	frc_byte_if.sink      byte_ch,
	frc_result_if.source  result_ch,
	frc_cfg_if.sink       cfg_ch
);

	logic [frc_pkg::HASH_W-1:0] magic_word;
	logic [frc_pkg::WORD_W-1:0] expected_version;
	logic                       out_free;
	logic                       res_valid;
	frc_pkg::result_t           res;

	// Registers must only be written between records, so the record logic may
	// read them directly; the block itself does not enforce this.
	frc_cfg_regs u_cfg_regs (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_ch),
		.magic_word       (magic_word),
		.expected_version (expected_version)
	);

	// Input register, header capture, hash and status.
	frc_record u_record (
		.clk              (clk),
		.arst_n           (arst_n),
		.byte_ch          (byte_ch),
		.magic_word       (magic_word),
		.expected_version (expected_version),
		.out_free         (out_free),
		.res_valid        (res_valid),
		.res              (res)
	);

	// Result register; it decouples the consumer from the byte stream.
	frc_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.out_free  (out_free),
		.result_ch (result_ch)
	);

endmodule

FILE: rtl/frc_checker.sv
// ----------------------------------------------------------------------------
// frc_checker: port-level checks for the framed record checker
// Watches the result channel of the top level and is bound to it.
// ----------------------------------------------------------------------------
module frc_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        res_valid,
	input  logic                        res_ready,
	input  logic [2:0]                  status,
	input  logic                        record_ok,
	input  logic [frc_pkg::HASH_W-1:0]  payload_hash
);

	// A stalled result keeps its valid and its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(status)
			&& $stable(record_ok) && $stable(payload_hash))
		else $error("result changed while stalled");

	// The ok flag agrees with the status code.
	a_ok_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> record_ok == (status == frc_pkg::ST_OK))
		else $error("record_ok disagrees with status");

	// Only defined status codes are shown; the checksum code is the last one.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> status <= frc_pkg::ST_CHECKSUM)
		else $error("undefined status code");

	// A record too short to hold a payload hashes nothing.
	a_short_hash: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == frc_pkg::ST_SHORT |-> payload_hash == frc_pkg::FNV_BASIS)
		else $error("short record with non-basis hash");

endmodule

bind framed_record_checker_fnv1a64_top frc_checker u_frc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (result_ch.valid),
	.res_ready    (result_ch.ready),
	.status       (result_ch.status),
	.record_ok    (result_ch.record_ok),
	.payload_hash (result_ch.payload_hash)
);

FILE: bench/tb_framed_record_checker_fnv1a64_top.sv
// ----------------------------------------------------------------------------
// tb_framed_record_checker_fnv1a64_top: self-checking bench for the checker
// Streams framed records (well-formed, corrupted, truncated and noise) into
// the block with random gaps and back-pressure, predicts every verdict with
// an independent record model, and checks each result field by field.
// ----------------------------------------------------------------------------
module tb_framed_record_checker_fnv1a64_top;

	// FNV-1a 64 prime, 2^40 + 0x1B3.
	localparam logic [frc_pkg::HASH_W-1:0] FNV_PRIME_C = 64'h0000_0100_0000_01B3;
	localparam int NUM_PHASES   = 6;
	localparam int PHASE_BYTES  = 230;
	// Settling time after the last verdict, with some slack.
	localparam int DRAIN_CYCLES = 8;
	// Slowest run: about 1700 bytes, each behind a random gap, plus result
	// stalls and register writes. Taken several times over.
	localparam int LIMIT_CYCLES = 600000;

	typedef enum int {
		REC_OK,
		REC_SHORT,
		REC_MAGIC,
		REC_VERSION,
		REC_LENGTH,
		REC_CHECKSUM,
		REC_MULTI,
		REC_NOISE
	} rec_kind_e;

	typedef struct packed {
		logic [frc_pkg::BYTE_W-1:0] data;
		logic                       last;
	} rec_byte_t;

	logic clk = 1'b0;
	logic arst_n;

	frc_byte_if   byte_ch ();
	frc_result_if result_ch ();
	frc_cfg_if    cfg_ch ();

	framed_record_checker_fnv1a64_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.result_ch (result_ch),
		.cfg_ch    (cfg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Bytes waiting to be offered, and verdicts the model expects in order.
	rec_byte_t          byte_backlog[$];
	frc_pkg::result_t   pending_verdicts[$];

	// Register copies as the block should hold them.
	logic [frc_pkg::HASH_W-1:0] want_magic;
	logic [frc_pkg::WORD_W-1:0] want_version;

	// Per-record state of the model.
	logic [frc_pkg::COUNT_W-1:0] seen_count;
	logic                        magic_miss;
	logic [frc_pkg::WORD_W-1:0]  ver_cap;
	logic [frc_pkg::WORD_W-1:0]  len_cap;
	logic [frc_pkg::HASH_W-1:0]  sum_cap;
	logic [frc_pkg::HASH_W-1:0]  hash_acc;

	// When set, neither side inserts gaps, so the block runs at full rate.
	logic calm;

	int errors = 0;
	int bytes_queued;
	int records_queued;
	int settings_used;
	int verdict_tally[6];
	int cycle_count = 0;
	int gap_left;
	int stall_left;
	rec_byte_t        next_byte;
	frc_pkg::result_t head_verdict;

	function automatic logic [frc_pkg::HASH_W-1:0] fnv1a_fold(
			input logic [frc_pkg::HASH_W-1:0] h,
			input logic [frc_pkg::BYTE_W-1:0] b);
		return (h ^ {{(frc_pkg::HASH_W-frc_pkg::BYTE_W){1'b0}}, b}) * FNV_PRIME_C;
	endfunction

	function automatic void clear_record_state();
		seen_count = '0;
		magic_miss = 1'b0;
		ver_cap    = '0;
		len_cap    = '0;
		sum_cap    = '0;
		hash_acc   = frc_pkg::FNV_BASIS;
	endfunction

	// Folds one accepted byte into the record model. On the final byte of a
	// record it works out the verdict and queues it.
	function automatic void absorb_record_byte(input logic [frc_pkg::BYTE_W-1:0] b,
			input logic last_b);
		int               p;
		frc_pkg::status_t st;
		frc_pkg::result_t r;
		p = int'(seen_count[4:0]);
		if (seen_count < frc_pkg::MAGIC_END) begin
			if (want_magic[p*8 +: 8] != b)
				magic_miss = 1'b1;
		end else if (seen_count < frc_pkg::VERSION_END) begin
			ver_cap = ver_cap | (frc_pkg::WORD_W'(b) << ((p - 8) * 8));
		end else if (seen_count < frc_pkg::LENGTH_END) begin
			len_cap = len_cap | (frc_pkg::WORD_W'(b) << ((p - 12) * 8));
		end else if (seen_count < frc_pkg::HEADER_BYTES) begin
			sum_cap = sum_cap | (frc_pkg::HASH_W'(b) << ((p - 16) * 8));
		end else begin
			hash_acc = fnv1a_fold(hash_acc, b);
		end
		// The counter saturates rather than wrapping.
		if (seen_count != frc_pkg::COUNT_MAX)
			seen_count = seen_count + 1'b1;
		if (last_b) begin
			if (seen_count < frc_pkg::HEADER_BYTES)
				st = frc_pkg::ST_SHORT;
			else if (magic_miss)
				st = frc_pkg::ST_MAGIC;
			else if (ver_cap != want_version)
				st = frc_pkg::ST_VERSION;
			else if (seen_count == frc_pkg::COUNT_MAX
					|| seen_count - frc_pkg::HEADER_BYTES != {1'b0, len_cap})
				st = frc_pkg::ST_LENGTH;
			else if (hash_acc != sum_cap)
				st = frc_pkg::ST_CHECKSUM;
			else
				st = frc_pkg::ST_OK;
			r.status       = st;
			r.record_ok    = (st == frc_pkg::ST_OK);
			r.payload_hash = hash_acc;
			pending_verdicts = {pending_verdicts, r};
			clear_record_state();
		end
	endfunction

	// Most gaps are short, a few are long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// Record mix: mostly well-formed so that the hash and the later checks
	// get exercised, with each failure kind and some plain noise.
	function automatic rec_kind_e pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return REC_OK;
		else if (r < 60)
			return REC_CHECKSUM;
		else if (r < 68)
			return REC_LENGTH;
		else if (r < 75)
			return REC_VERSION;
		else if (r < 82)
			return REC_MAGIC;
		else if (r < 88)
			return REC_MULTI;
		else if (r < 95)
			return REC_SHORT;
		else
			return REC_NOISE;
	endfunction

	// Payload length for framed records; total length for short and noise.
	function automatic int pick_size(input rec_kind_e kind);
		int r;
		r = $urandom_range(0, 99);
		if (kind == REC_SHORT)
			return $urandom_range(1, 23);
		else if (kind == REC_NOISE)
			return $urandom_range(1, 48);
		else if (r < 80)
			return $urandom_range(0, 12);
		else if (r < 97)
			return $urandom_range(13, 40);
		else
			return $urandom_range(41, 200);
	endfunction

	// Builds one record against the current register copies and queues its
	// bytes. For short and noise records size is the whole record length,
	// otherwise it is the payload length.
	task automatic build_record(input rec_kind_e kind, input int size);
		logic [frc_pkg::BYTE_W-1:0] body[$];
		logic [frc_pkg::BYTE_W-1:0] payload[$];
		logic [frc_pkg::HASH_W-1:0] mg;
		logic [frc_pkg::WORD_W-1:0] ver;
		logic [frc_pkg::WORD_W-1:0] len;
		logic [frc_pkg::HASH_W-1:0] sum;
		rec_byte_t                  item;
		int                         i;
		int                         plen;
		plen = (kind == REC_SHORT || kind == REC_NOISE) ? 0 : size;
		sum  = frc_pkg::FNV_BASIS;
		for (i = 0; i < plen; i++) begin
			payload = {payload, frc_pkg::BYTE_W'($urandom)};
			sum = fnv1a_fold(sum, payload[i]);
		end
		mg  = want_magic;
		ver = want_version;
		len = frc_pkg::WORD_W'(plen);
		case (kind)
			REC_MAGIC: begin
				mg[$urandom_range(0, 63)] ^= 1'b1;
			end
			REC_VERSION: begin
				if ($urandom_range(0, 1))
					ver[$urandom_range(0, 31)] ^= 1'b1;
				else
					ver = $urandom;
				if (ver == want_version)
					ver = ~ver;
			end
			REC_LENGTH: begin
				case ($urandom_range(0, 3))
					0: len = frc_pkg::WORD_W'(plen + 1);
					1: len = frc_pkg::WORD_W'(plen - 1);
					2: len = '1;
					default: len = $urandom;
				endcase
				if (len == frc_pkg::WORD_W'(plen))
					len = len + 1'b1;
			end
			REC_CHECKSUM: begin
				if ($urandom_range(0, 1))
					sum[$urandom_range(0, 63)] ^= 1'b1;
				else
					sum = {$urandom, $urandom};
			end
			REC_MULTI: begin
				// Several checks can fail at once; the earliest one must win.
				if ($urandom_range(0, 1))
					mg[$urandom_range(0, 63)] ^= 1'b1;
				ver = ver ^ frc_pkg::WORD_W'($urandom_range(0, 1));
				if ($urandom_range(0, 1))
					len = $urandom;
				sum[$urandom_range(0, 63)] ^= 1'b1;
			end
			default: begin
			end
		endcase
		if (kind == REC_NOISE) begin
			for (i = 0; i < size; i++)
				body = {body, frc_pkg::BYTE_W'($urandom)};
		end else begin
			for (i = 0; i < 8; i++)
				body = {body, mg[i*8 +: 8]};
			for (i = 0; i < 4; i++)
				body = {body, ver[i*8 +: 8]};
			for (i = 0; i < 4; i++)
				body = {body, len[i*8 +: 8]};
			for (i = 0; i < 8; i++)
				body = {body, sum[i*8 +: 8]};
			for (i = 0; i < plen; i++)
				body = {body, payload[i]};
			// A truncated record keeps only the front of a good header.
			if (kind == REC_SHORT) begin
				while (body.size() > size)
					void'(body.pop_back());
			end
		end
		for (i = 0; i < body.size(); i++) begin
			item.data = body[i];
			item.last = (i == body.size() - 1);
			byte_backlog = {byte_backlog, item};
		end
		bytes_queued += body.size();
		records_queued++;
	endtask

	// Register write through the configuration channel. The model copy is
	// updated once the write has been accepted; unknown indexes are ignored.
	task automatic write_reg(input logic [frc_pkg::CFG_IDX_W-1:0] idx,
			input logic [frc_pkg::CFG_DAT_W-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == frc_pkg::REG_MAGIC)
			want_magic = value;
		else if (idx == frc_pkg::REG_VERSION)
			want_version = value[frc_pkg::WORD_W-1:0];
	endtask

	// Waits until every queued byte has gone in and every verdict has come
	// out, then lets the pipeline settle.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (byte_backlog.size() != 0 || byte_ch.valid
				|| pending_verdicts.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Byte driver. An accepted byte goes into the model at the edge where it
	// is taken; a new byte is offered only when the current one is gone.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_ch.valid     <= 1'b0;
			byte_ch.data_byte <= '0;
			byte_ch.last_byte <= 1'b0;
			gap_left = 0;
			clear_record_state();
		end else begin
			if (byte_ch.valid && byte_ch.ready)
				absorb_record_byte(byte_ch.data_byte, byte_ch.last_byte);
			if (!byte_ch.valid || byte_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					byte_ch.valid <= 1'b0;
				end else if (byte_backlog.size() != 0) begin
					next_byte = byte_backlog.pop_front();
					byte_ch.valid     <= 1'b1;
					byte_ch.data_byte <= next_byte.data;
					byte_ch.last_byte <= next_byte.last;
					gap_left = calm ? 0 : pick_gap();
				end else begin
					byte_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor. Every accepted verdict is matched against the oldest
	// expectation; ready is dropped at random to stall the block.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (pending_verdicts.size() == 0) begin
					$display("%0t: verdict with none expected: status %0d hash %h",
						$time, result_ch.status, result_ch.payload_hash);
					errors++;
				end else begin
					head_verdict = pending_verdicts.pop_front();
					if (result_ch.status != head_verdict.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, head_verdict.status, result_ch.status);
						errors++;
					end
					if (result_ch.record_ok != head_verdict.record_ok) begin
						$display("%0t: record_ok expected %0b actual %0b",
							$time, head_verdict.record_ok, result_ch.record_ok);
						errors++;
					end
					if (result_ch.payload_hash != head_verdict.payload_hash) begin
						$display("%0t: payload_hash expected %h actual %h",
							$time, head_verdict.payload_hash, result_ch.payload_hash);
						errors++;
					end
				end
				if (result_ch.status < 6)
					verdict_tally[result_ch.status]++;
			end
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int ph;
		int target;
		rec_kind_e kind;
		// The configuration inputs are known from time zero; the byte and
		// result sides are set by their own blocks while reset is held.
		arst_n            = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = '0;
		cfg_ch.data       = '0;
		calm              = 1'b0;
		bytes_queued      = 0;
		records_queued    = 0;
		settings_used     = 1;
		want_magic        = frc_pkg::MAGIC_RESET;
		want_version      = frc_pkg::VERSION_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed records with the reset register values: a one-byte record,
		// a record one byte short of a full header, good records with empty
		// and one-byte payloads, each single failure, and stacked failures.
		build_record(REC_SHORT, 1);
		build_record(REC_SHORT, 23);
		build_record(REC_OK, 0);
		build_record(REC_OK, 1);
		build_record(REC_MAGIC, 2);
		build_record(REC_VERSION, 1);
		build_record(REC_LENGTH, 0);
		build_record(REC_CHECKSUM, 2);
		build_record(REC_MULTI, 1);
		wait_drained();

		// Random phases, each under its own register setting. Writes happen
		// only once the block has gone quiet.
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin
					write_reg(frc_pkg::REG_MAGIC, '0);
					write_reg(frc_pkg::REG_VERSION, '0);
					// An unknown index must leave both registers alone.
					write_reg(frc_pkg::CFG_IDX_W'($urandom_range(2, 15)),
						{$urandom, $urandom});
				end
				1: begin
					write_reg(frc_pkg::REG_MAGIC, '1);
					write_reg(frc_pkg::REG_VERSION, '1);
				end
				NUM_PHASES - 1: begin
					write_reg(frc_pkg::REG_MAGIC, frc_pkg::MAGIC_RESET);
					write_reg(frc_pkg::REG_VERSION, {$urandom, frc_pkg::VERSION_RESET});
				end
				default: begin
					write_reg(frc_pkg::REG_MAGIC, {$urandom, $urandom});
					// Upper data bits are junk; only the low word is kept.
					write_reg(frc_pkg::REG_VERSION, {$urandom, 32'($urandom_range(0, 9))});
					if ($urandom_range(0, 1))
						write_reg(frc_pkg::CFG_IDX_W'($urandom_range(2, 15)),
							{$urandom, $urandom});
				end
			endcase
			settings_used++;
			calm = ($urandom_range(0, 3) == 0);
			target = bytes_queued + PHASE_BYTES;
			while (bytes_queued < target) begin
				kind = pick_kind();
				build_record(kind, pick_size(kind));
			end
			wait_drained();
		end
		calm = 1'b0;

		$display("Ran %0d records, %0d bytes, under %0d register settings.",
			records_queued, bytes_queued, settings_used);
		$display("Verdicts ok %0d, short %0d, magic %0d, version %0d, length %0d, checksum %0d.",
			verdict_tally[0], verdict_tally[1], verdict_tally[2],
			verdict_tally[3], verdict_tally[4], verdict_tally[5]);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
